>>> sv/demand_paging_frame_allocator_defines.svh
// ---------------------------------------------------------------------------
// Demand paging frame allocator: assertion macros
// Shared property wrappers, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef DEMAND_PAGING_FRAME_ALLOCATOR_DEFINES_SVH
`define DEMAND_PAGING_FRAME_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define DPFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DPFA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/dpfa_pkg.sv
// ---------------------------------------------------------------------------
// dpfa_pkg
// Types and codes of the demand paging frame allocator.
// ---------------------------------------------------------------------------
package dpfa_pkg;

  localparam int FRAME_W = 16;
  localparam int COUNT_W = 8;
  localparam int FAULT_W = 16;
  localparam int CFG_IDX_W = 2;

  typedef logic [1:0] status_t;

  localparam status_t ST_HIT     = 2'd0;
  localparam status_t ST_FAULT   = 2'd1;
  localparam status_t ST_OOM     = 2'd2;
  localparam status_t ST_REFUSED = 2'd3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_TOTAL_FRAMES = 2'd0;
  localparam cfg_idx_t CFG_FIRST_FREE   = 2'd1;

  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] frame;
    logic [COUNT_W-1:0] count;
  } pte_t;

endpackage

>>> sv/demand_paging_frame_allocator.sv
// ---------------------------------------------------------------------------
// demand_paging_frame_allocator
// Per-process single-level page tables in one synchronous RAM, with frame
// allocation on a miss, per-process fault counters and an out-of-memory halt.
// ---------------------------------------------------------------------------
// channel  | handshake                   | payload
// req      | req_valid / req_stall       | process_id, virtual_page
// rsp      | rsp_valid / rsp_stall       | status, frame_number,
//          |                             | reference_count, fault_count
// cfg      | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// A request reads the table RAM on acceptance; the update and write-back
// then run against the registered read data.
// After reset a clearing pass writes every table entry invalid, one per cycle,
// 2**(clog2(NUM_PROCESSES)+clog2(PAGES_PER_PROCESS)) entries, 4096 by default.
// A stalled result holds the update stage; the next request is taken only
// after that result has been moved into the output register.
// ---------------------------------------------------------------------------
`include "demand_paging_frame_allocator_defines.svh"

module demand_paging_frame_allocator #(
  parameter int NUM_PROCESSES     = 16,
  parameter int PAGES_PER_PROCESS = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [3:0]                     process_id,
  input  logic [7:0]                     virtual_page,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output dpfa_pkg::status_t              status,
  output logic [dpfa_pkg::FRAME_W-1:0]   frame_number,
  output logic [dpfa_pkg::COUNT_W-1:0]   reference_count,
  output logic [dpfa_pkg::FAULT_W-1:0]   fault_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  dpfa_pkg::cfg_idx_t             cfg_index,
  input  logic [15:0]                    cfg_data
);
  import dpfa_pkg::*;

  localparam int PID_BITS = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
  localparam int PG_BITS  = $clog2(PAGES_PER_PROCESS);
  localparam int PIDX_W   = (PID_BITS > 4) ? PID_BITS : 4;
  localparam int AW       = PID_BITS + PG_BITS;
  localparam int DEPTH    = 1 << AW;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;

  logic [1:0]         state, state_next;
  logic [AW-1:0]      clr_addr;
  logic [15:0]        total_frames;
  logic [16:0]        next_frame;
  logic               halted;
  logic [FAULT_W-1:0] fault_cnt [NUM_PROCESSES];

  pte_t               mem [DEPTH];
  pte_t               rd_q;
  logic [3:0]         pid_q;
  logic [7:0]         page_q;

  logic               req_go, look_go;
  logic [PIDX_W-1:0]  pid_in_ext, pid_q_ext;
  logic [AW-1:0]      rd_addr, look_addr;
  logic [PID_BITS-1:0] pidx;
  logic               pid_ok, page_ok;
  logic [FAULT_W-1:0] fc;

  // lookup results
  status_t            res_status;
  logic [FRAME_W-1:0] res_frame;
  logic [COUNT_W-1:0] res_count;
  logic [FAULT_W-1:0] res_fc;
  logic               upd_we, set_halt, alloc;
  pte_t               upd_wd;

  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  pte_t               mem_wd;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);
  assign req_go    = req_valid && !req_stall;
  assign look_go   = (state == S_LOOK) && (!rsp_valid || !rsp_stall);

  assign pid_in_ext = PIDX_W'(process_id);
  assign pid_q_ext  = PIDX_W'(pid_q);
  assign rd_addr    = {pid_in_ext[PID_BITS-1:0], virtual_page[PG_BITS-1:0]};
  assign pidx       = pid_q_ext[PID_BITS-1:0];
  assign look_addr  = {pidx, page_q[PG_BITS-1:0]};
  assign pid_ok     = (32'(pid_q) < NUM_PROCESSES);
  assign page_ok    = (32'(page_q) < PAGES_PER_PROCESS);
  assign fc         = pid_ok ? fault_cnt[pidx] : '0;

  always_comb begin
    res_status = ST_REFUSED;
    res_frame  = '0;
    res_count  = '0;
    res_fc     = fc;
    upd_we     = 1'b0;
    upd_wd     = rd_q;
    set_halt   = 1'b0;
    alloc      = 1'b0;
    if (!pid_ok || halted || !page_ok) begin
      res_status = ST_REFUSED;
    end else if (rd_q.valid) begin
      res_status   = ST_HIT;
      upd_we       = 1'b1;
      upd_wd.count = rd_q.count + COUNT_W'(1);
      res_frame    = rd_q.frame;
      res_count    = upd_wd.count;
    end else if (next_frame >= {1'b0, total_frames}) begin
      res_status = ST_OOM;
      set_halt   = 1'b1;
    end else begin
      res_status   = ST_FAULT;
      alloc        = 1'b1;
      upd_we       = 1'b1;
      upd_wd.valid = 1'b1;
      upd_wd.frame = next_frame[FRAME_W-1:0];
      upd_wd.count = COUNT_W'(1);
      res_frame    = next_frame[FRAME_W-1:0];
      res_count    = COUNT_W'(1);
      res_fc       = (fc == '1) ? fc : fc + FAULT_W'(1);
    end
  end

  // single write port: clearing sweep or lookup write-back
  always_comb begin
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
      mem_wd = '0;
    end else begin
      mem_we = look_go && upd_we;
      mem_wa = look_addr;
      mem_wd = upd_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (req_go) begin
      rd_q   <= mem[rd_addr];
      pid_q  <= process_id;
      page_q <= virtual_page;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (&clr_addr) state_next = S_IDLE;
      S_IDLE:  if (req_go) state_next = S_LOOK;
      S_LOOK:  if (look_go) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_frames <= 16'd256;
      next_frame   <= '0;
      halted       <= 1'b0;
      for (int i = 0; i < NUM_PROCESSES; i++) fault_cnt[i] <= '0;
    end else begin
      if (look_go && set_halt) halted <= 1'b1;
      if (look_go && alloc) begin
        next_frame      <= next_frame + 17'd1;
        fault_cnt[pidx] <= res_fc;
      end
      // the user must send config only while idle so it never collides with an update; not enforced here
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TOTAL_FRAMES: total_frames <= cfg_data;
          CFG_FIRST_FREE:   next_frame   <= {1'b0, cfg_data};
          default:          ;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (look_go) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (look_go) begin
      status          <= res_status;
      frame_number    <= res_frame;
      reference_count <= res_count;
      fault_count     <= pid_ok ? res_fc : '0;
    end
  end

  `DPFA_ASSERT_NOW(a_no_req_in_clear, state == S_CLEAR, req_stall, "request taken during clear")
  `DPFA_ASSERT_NXT(a_halt_sticks, halted, halted, "halt dropped")
  `DPFA_ASSERT_NXT(a_hold_on_stall, (state == S_LOOK) && rsp_valid && rsp_stall, state == S_LOOK, "update ran into a stalled result")
  `DPFA_ASSERT_NOW(a_oom_halts, rsp_valid && (status == ST_OOM), halted, "out of memory without halt")

endmodule

>>> tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: demand paging frame allocator testbench
// Sends page references, predicts each lookup result from a private copy of
// the page tables, fault counters and frame pointer, and checks every result
// in order. Runs several frame-range settings and ends with out-of-memory halt.
// ---------------------------------------------------------------------------
import dpfa_pkg::*;

localparam int NUM_PROC    = 16;
localparam int PAGES       = 256;
localparam int TABLE_DEPTH = NUM_PROC * PAGES;

typedef struct packed {
  status_t     status;
  logic [15:0] frame;
  logic [7:0]  count;
  logic [15:0] faults;
} lookup_result_t;

class page_table_checker;
  logic [15:0]    total_frames;
  logic [15:0]    first_free;
  logic [16:0]    next_frame;
  bit             halted;
  pte_t           page_tbl [TABLE_DEPTH];
  logic [15:0]    fault_cnt [NUM_PROC];
  int unsigned    mapped [$];
  lookup_result_t pending_lookups [$];
  int             errors, n_refs, n_hit, n_fault, n_oom, n_refused, n_wrap;

  function void reset_state();
    total_frames = 16'd256;
    first_free   = 16'd0;
    next_frame   = 17'd0;
    halted       = 1'b0;
    foreach (page_tbl[i]) page_tbl[i] = '0;
    foreach (fault_cnt[i]) fault_cnt[i] = '0;
  endfunction

  function void note_config(cfg_idx_t idx, logic [15:0] val);
    case (idx)
      CFG_TOTAL_FRAMES: total_frames = val;
      CFG_FIRST_FREE: begin
        first_free = val;
        next_frame = {1'b0, val};
      end
      default: ;
    endcase
  endfunction

  function void note_reference(logic [3:0] pid, logic [7:0] page);
    lookup_result_t r;
    int unsigned    idx;
    r = '0;
    n_refs++;
    if (pid >= NUM_PROC) begin
      r.status = ST_REFUSED;
      n_refused++;
    end else if (halted || page >= PAGES) begin
      r.status = ST_REFUSED;
      r.faults = fault_cnt[pid];
      n_refused++;
    end else begin
      idx = pid * PAGES + page;
      if (page_tbl[idx].valid) begin
        page_tbl[idx].count = page_tbl[idx].count + 8'd1;
        if (page_tbl[idx].count == 8'd0) n_wrap++;
        r.status = ST_HIT;
        r.frame  = page_tbl[idx].frame;
        r.count  = page_tbl[idx].count;
        r.faults = fault_cnt[pid];
        n_hit++;
      end else if (next_frame >= {1'b0, total_frames}) begin
        halted   = 1'b1;
        r.status = ST_OOM;
        r.faults = fault_cnt[pid];
        n_oom++;
      end else begin
        page_tbl[idx].valid = 1'b1;
        page_tbl[idx].frame = next_frame[15:0];
        page_tbl[idx].count = 8'd1;
        next_frame = next_frame + 17'd1;
        if (fault_cnt[pid] != 16'hFFFF) fault_cnt[pid] = fault_cnt[pid] + 16'd1;
        mapped.push_back(idx);
        r.status = ST_FAULT;
        r.frame  = page_tbl[idx].frame;
        r.count  = 8'd1;
        r.faults = fault_cnt[pid];
        n_fault++;
      end
    end
    pending_lookups.push_back(r);
  endfunction

  function void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function void check_lookup(status_t st, logic [15:0] fr, logic [7:0] cnt,
                             logic [15:0] fc);
    lookup_result_t want;
    if (pending_lookups.size() == 0) begin
      errors++;
      $display("%0t: result with none expected, actual status %0d frame %0d count %0d faults %0d",
               $time, st, fr, cnt, fc);
      return;
    end
    want = pending_lookups.pop_front();
    compare_field("status", 16'(want.status), 16'(st));
    compare_field("frame_number", want.frame, fr);
    compare_field("reference_count", 16'(want.count), 16'(cnt));
    compare_field("fault_count", want.faults, fc);
  endfunction
endclass

module tb_top;
  localparam int       HOLD_CYCLES = 60;
  localparam int       QUIET_LIMIT = 20000;  // covers the table clearing pass
  localparam cfg_idx_t CFG_SPARE_2 = 2'd2;
  localparam cfg_idx_t CFG_SPARE_3 = 2'd3;

  // extremes of both fields, bit patterns, and back-to-back reuse of a page
  localparam logic [11:0] FIRST_REFS [16] = '{
    12'h000, 12'h000, 12'hFFF, 12'hFFF, 12'h0FF, 12'hF00, 12'h780, 12'h87F,
    12'h000, 12'h5AA, 12'hA55, 12'h303, 12'h303, 12'h303, 12'h304, 12'h303
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [3:0]  process_id = '0;
  logic [7:0]  virtual_page = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  status_t     status;
  logic [15:0] frame_number;
  logic [7:0]  reference_count;
  logic [15:0] fault_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = CFG_TOTAL_FRAMES;
  logic [15:0] cfg_data = '0;

  page_table_checker sb = new();
  int          idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_rsp = 1'b0;
  logic [11:0] hot_idx [8];

  demand_paging_frame_allocator #(
    .NUM_PROCESSES(NUM_PROC),
    .PAGES_PER_PROCESS(PAGES)
  ) u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .process_id(process_id), .virtual_page(virtual_page),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .frame_number(frame_number),
    .reference_count(reference_count), .fault_count(fault_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // valid is left high after the last write; caller drops it
  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, val);
  endtask

  // valid stays high after acceptance so the next request can follow at once
  task automatic send_ref(logic [3:0] pid, logic [7:0] page);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_valid    <= 1'b1;
    process_id   <= pid;
    virtual_page <= page;
    do @(posedge clk); while (req_stall);
    sb.note_reference(pid, page);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending_lookups.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 30;
    endcase
  endfunction

  // mostly hot pages and revisits so counts wrap; the rest spreads faults
  task automatic run_random(int n, bit allow_oom, bit paced);
    logic [11:0] idx;
    int          r;
    if (!paced) begin
      idle_pct  = 0;
      stall_pct = 0;
    end
    for (int i = 0; i < n; i++) begin
      if (paced && i % 50 == 0) begin
        idle_pct  = pick_pct();
        stall_pct = pick_pct();
      end
      r = $urandom_range(0, 99);
      if (r < 30)
        idx = hot_idx[0];
      else if (r < 50)
        idx = hot_idx[$urandom_range(1, 7)];
      else if (r < 70 && sb.mapped.size() != 0)
        idx = 12'(sb.mapped[$urandom_range(0, sb.mapped.size() - 1)]);
      else
        idx = 12'($urandom_range(0, TABLE_DEPTH - 1));
      // keep the halt for the last phase: turn a would-be miss into a hit
      if (!allow_oom && !sb.page_tbl[idx].valid && sb.next_frame >= {1'b0, sb.total_frames}
          && sb.mapped.size() != 0)
        idx = 12'(sb.mapped[$urandom_range(0, sb.mapped.size() - 1)]);
      send_ref(idx[11:8], idx[7:0]);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall)
      sb.check_lookup(status, frame_number, reference_count, fault_count);
  end

  initial begin : rsp_pacing
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_stall <= 1'b0;
        hold_rsp = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    logic [11:0] probe;
    sb.reset_state();
    foreach (hot_idx[i]) hot_idx[i] = 12'($urandom_range(0, TABLE_DEPTH - 1));
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // full frame range
    write_reg(CFG_TOTAL_FRAMES, 16'hFFFF);
    write_reg(CFG_FIRST_FREE, 16'h0000);
    cfg_valid <= 1'b0;
    foreach (FIRST_REFS[i]) send_ref(FIRST_REFS[i][11:8], FIRST_REFS[i][7:0]);
    run_random(250, 1'b0, 1'b1);
    // long receiver hold while requests keep coming: pipeline backs up
    hold_rsp = 1'b1;
    run_random(30, 1'b0, 1'b0);
    run_random(270, 1'b0, 1'b1);
    drain();

    // unused indexes must leave the frame range alone
    write_reg(CFG_SPARE_2, 16'hFFFF);
    write_reg(CFG_SPARE_3, 16'h0000);
    write_reg(CFG_TOTAL_FRAMES, 16'd4000);
    write_reg(CFG_FIRST_FREE, 16'd2500);
    cfg_valid <= 1'b0;
    run_random(250, 1'b0, 1'b1);
    drain();
    run_random(250, 1'b0, 1'b1);
    drain();

    // frames near the top of the range
    write_reg(CFG_FIRST_FREE, 16'd65000);
    write_reg(CFG_TOTAL_FRAMES, 16'hFFFF);
    cfg_valid <= 1'b0;
    run_random(450, 1'b0, 1'b1);
    drain();

    // no frames at all: only mapped pages are referenced
    write_reg(CFG_TOTAL_FRAMES, 16'h0000);
    cfg_valid <= 1'b0;
    run_random(100, 1'b0, 1'b1);
    drain();

    // last frames, then out of memory and the latched halt; no idling from here
    idle_pct  = 0;
    stall_pct = 0;
    write_reg(CFG_TOTAL_FRAMES, 16'hFFFF);
    write_reg(CFG_FIRST_FREE, 16'd65530);
    cfg_valid <= 1'b0;
    probe = 12'h900;
    for (int k = 0; k < 7; k++) begin
      while (sb.page_tbl[probe].valid) probe++;
      send_ref(probe[11:8], probe[7:0]);
      probe++;
    end
    send_ref(hot_idx[0][11:8], hot_idx[0][7:0]);
    run_random(40, 1'b1, 1'b0);
    drain();
    write_reg(CFG_FIRST_FREE, 16'hFFFF);
    write_reg(CFG_TOTAL_FRAMES, 16'h0000);
    cfg_valid <= 1'b0;
    run_random(10, 1'b1, 1'b0);
    drain();
    repeat (8) @(posedge clk);

    $display("Covered %0d references: %0d hits, %0d faults, %0d out of memory, %0d refused",
             sb.n_refs, sb.n_hit, sb.n_fault, sb.n_oom, sb.n_refused);
    $display("Count wrapped %0d times over %0d mapped pages, with %0d mismatches",
             sb.n_wrap, sb.mapped.size(), sb.errors);
    if (sb.errors == 0 && sb.pending_lookups.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule

>>> demand_paging_frame_allocator.f
+incdir+sv
sv/dpfa_pkg.sv
sv/demand_paging_frame_allocator.sv
tb/sv/tb_top.sv
